@@ hw/rtl/psgmq_pkg.sv @@
// Shared types, constants and helpers for the periodic grid sphere mark and query block.
// Used by every module in hw/rtl; depends on nothing else.
package psgmq_pkg;

    localparam int GRID_SIZE  = 64;
    localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int EDGE_W     = 7;
    localparam int COORD_W    = 6;
    localparam int HALF_W     = 5;
    localparam int LIMIT_W    = 12;
    localparam int SQ_W       = 10;
    localparam int EE_W       = 13;
    localparam int ROW_W      = 12;
    localparam int WRAP_W     = 8;

    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] center_z;
        logic [HALF_W-1:0]  half_extent;
        logic [LIMIT_W-1:0] radius_sq_limit;
    } t_item;

    typedef struct packed {
        logic              we;
        logic              re;
        logic              wdata;
        logic [ADDR_W-1:0] addr;
    } t_ram_req;

    // An edge of zero counts as one; an edge above the grid saturates to it.
    function automatic logic [EDGE_W-1:0] edge_clamp(input logic [EDGE_W-1:0] e);
        logic [EDGE_W-1:0] r;
        r = e;
        if (e == '0) r = EDGE_W'(1);
        if (e > EDGE_W'(GRID_SIZE)) r = EDGE_W'(GRID_SIZE);
        return r;
    endfunction

endpackage

@@ hw/rtl/psgmq_mark_ram.sv @@
// Single-port one-bit mark memory, one cell per flat grid address, registered read.
// Depends on psgmq_pkg.
module psgmq_mark_ram
    import psgmq_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output logic     o_rd_data
);

    logic r_mem [CELL_COUNT];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/psgmq_scan.sv @@
// Sequencer and shared coordinate unit: clears the grid after reset, wraps the start
// coordinates, then walks the scan cube one cell a cycle. Depends on psgmq_pkg.
module psgmq_scan
    import psgmq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_item             i_item,
    input  logic [EDGE_W-1:0] i_edge,
    input  logic              i_out_free,
    input  logic              i_rd_data,
    output logic              o_ready,
    output logic              o_done,
    output logic              o_hit,
    output t_ram_req          o_ram
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WRAP, S_MUL, S_BASE, S_SCAN, S_DRAIN, S_DONE
    } t_state;

    t_state                     r_state;
    t_item                      r_item;
    logic [ADDR_W-1:0]          r_clr;
    logic [EDGE_W-1:0]          r_e;
    logic [1:0]                 r_axis;
    logic signed [WRAP_W-1:0]   r_v;
    logic [COORD_W-1:0]         r_x0, r_y0, r_z0;
    logic [EE_W-1:0]            r_ee;
    logic [SQ_W-1:0]            r_hsq;
    logic signed [COORD_W-1:0]  r_l, r_m, r_n;
    logic [SQ_W-1:0]            r_sql, r_sqm, r_sqn;
    logic [COORD_W-1:0]         r_x, r_y, r_z;
    logic [ADDR_W-1:0]          r_rx;
    logic [ROW_W-1:0]           r_ry, r_ry0;
    logic                       r_rd_pend;
    logic                       r_hit;

    logic signed [COORD_W-1:0]  half_s;
    logic signed [WRAP_W-1:0]   edge_s;
    logic [COORD_W-1:0]         next_c;
    logic [LIMIT_W-1:0]         d2;
    logic                       in_sphere;
    logic [COORD_W-1:0]         e_last;

    function automatic logic [SQ_W-1:0] sq_step(input logic [SQ_W-1:0] sq,
                                                input logic signed [COORD_W-1:0] k);
        logic signed [LIMIT_W-1:0] t;
        t = $signed({2'b00, sq}) + ($signed(LIMIT_W'(k)) <<< 1) + LIMIT_W'(1);
        return t[SQ_W-1:0];
    endfunction

    assign half_s    = $signed({1'b0, r_item.half_extent});
    assign edge_s    = $signed({1'b0, r_e});
    assign e_last    = COORD_W'(r_e - EDGE_W'(1));
    assign d2        = LIMIT_W'(r_sql) + LIMIT_W'(r_sqm) + LIMIT_W'(r_sqn);
    assign in_sphere = d2 < r_item.radius_sq_limit;

    always_comb begin
        case (r_axis)
            2'd0:    next_c = r_item.center_y;
            default: next_c = r_item.center_z;
        endcase
    end

    always_comb begin
        o_ram.we    = 1'b0;
        o_ram.re    = 1'b0;
        o_ram.wdata = 1'b0;
        o_ram.addr  = r_rx + ADDR_W'(r_ry) + ADDR_W'(r_z);
        case (r_state)
            S_CLEAR: begin
                o_ram.we   = 1'b1;
                o_ram.addr = r_clr;
            end
            S_SCAN: begin
                o_ram.we    = in_sphere && (r_item.op == OP_MARK);
                o_ram.re    = in_sphere && (r_item.op == OP_QUERY);
                o_ram.wdata = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_rd_pend <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_rd_pend <= o_ram.re;
            if (r_rd_pend && i_rd_data) begin
                r_hit <= 1'b1;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(CELL_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_item  <= i_item;
                        r_e     <= edge_clamp(i_edge);
                        r_hit   <= 1'b0;
                        r_axis  <= 2'd0;
                        r_v     <= $signed({2'b00, i_item.center_x})
                                 - $signed({3'b000, i_item.half_extent});
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (r_v < 0) begin
                        r_v <= r_v + edge_s;
                    end else if (r_v >= edge_s) begin
                        r_v <= r_v - edge_s;
                    end else begin
                        case (r_axis)
                            2'd0:    r_x0 <= r_v[COORD_W-1:0];
                            2'd1:    r_y0 <= r_v[COORD_W-1:0];
                            default: r_z0 <= r_v[COORD_W-1:0];
                        endcase
                        r_v    <= $signed({2'b00, next_c})
                                - $signed({3'b000, r_item.half_extent});
                        r_axis <= r_axis + 2'd1;
                        if (r_axis == 2'd2) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_ee    <= EE_W'(r_e) * EE_W'(r_e);
                    r_hsq   <= SQ_W'(r_item.half_extent) * SQ_W'(r_item.half_extent);
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    r_rx    <= ADDR_W'(r_x0) * ADDR_W'(r_ee);
                    r_ry0   <= ROW_W'(r_y0) * ROW_W'(r_e);
                    r_ry    <= ROW_W'(r_y0) * ROW_W'(r_e);
                    r_x     <= r_x0;
                    r_y     <= r_y0;
                    r_z     <= r_z0;
                    r_l     <= -half_s;
                    r_m     <= -half_s;
                    r_n     <= -half_s;
                    r_sql   <= r_hsq;
                    r_sqm   <= r_hsq;
                    r_sqn   <= r_hsq;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_n != half_s) begin
                        r_n   <= r_n + COORD_W'(1);
                        r_sqn <= sq_step(r_sqn, r_n);
                        r_z   <= (r_z == e_last) ? '0 : r_z + COORD_W'(1);
                    end else begin
                        r_n   <= -half_s;
                        r_sqn <= r_hsq;
                        r_z   <= r_z0;
                        if (r_m != half_s) begin
                            r_m   <= r_m + COORD_W'(1);
                            r_sqm <= sq_step(r_sqm, r_m);
                            if (r_y == e_last) begin
                                r_y  <= '0;
                                r_ry <= '0;
                            end else begin
                                r_y  <= r_y + COORD_W'(1);
                                r_ry <= r_ry + ROW_W'(r_e);
                            end
                        end else begin
                            r_m   <= -half_s;
                            r_sqm <= r_hsq;
                            r_y   <= r_y0;
                            r_ry  <= r_ry0;
                            if (r_l != half_s) begin
                                r_l   <= r_l + COORD_W'(1);
                                r_sql <= sq_step(r_sql, r_l);
                                if (r_x == e_last) begin
                                    r_x  <= '0;
                                    r_rx <= '0;
                                end else begin
                                    r_x  <= r_x + COORD_W'(1);
                                    r_rx <= r_rx + ADDR_W'(r_ee);
                                end
                            end else begin
                                r_state <= S_DRAIN;
                            end
                        end
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_hit   = r_hit && (r_item.op == OP_QUERY);

endmodule

@@ hw/rtl/periodic_grid_sphere_mark_query.sv @@
// Top level of the periodic grid sphere mark and query block.
// Depends on psgmq_pkg, psgmq_scan and psgmq_mark_ram.
//
// One word in gives one word out. After reset the block clears its 262144-cell
// mark memory one cell a cycle, and takes no word until the clear is done; the edge
// register may be written meanwhile. A word then passes, on each axis, through a wrap
// step that adds or subtracts the edge from centre minus half extent until it lies in
// the grid, then the multiply and base address setup states, a scan of the cube of
// 2 * half_extent + 1 cells a side at one cell per cycle through the single memory
// port, a drain state to collect the last read and a done state that loads the result
// into the output register, which waits while that register still holds a stalled
// result. The next word is taken in the cycle after the result has been loaded.
module periodic_grid_sphere_mark_query
    import psgmq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [EDGE_W-1:0]  i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [COORD_W-1:0] i_center_x,
    input  logic [COORD_W-1:0] i_center_y,
    input  logic [COORD_W-1:0] i_center_z,
    input  logic [HALF_W-1:0]  i_half_extent,
    input  logic [LIMIT_W-1:0] i_radius_sq_limit,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit
);

    logic [EDGE_W-1:0] r_edge;
    logic              r_out_valid;
    logic              r_out_hit;

    t_item    item;
    t_ram_req ram_req;
    logic     rd_data;
    logic     scan_ready;
    logic     scan_done;
    logic     scan_hit;
    logic     out_free;
    logic     start;

    assign item.op              = i_op;
    assign item.center_x        = i_center_x;
    assign item.center_y        = i_center_y;
    assign item.center_z        = i_center_z;
    assign item.half_extent     = i_half_extent;
    assign item.radius_sq_limit = i_radius_sq_limit;

    assign out_free = !r_out_valid || !i_stall;
    assign start    = i_valid && scan_ready;

    psgmq_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (item),
        .i_edge     (r_edge),
        .i_out_free (out_free),
        .i_rd_data  (rd_data),
        .o_ready    (scan_ready),
        .o_done     (scan_done),
        .o_hit      (scan_hit),
        .o_ram      (ram_req)
    );

    psgmq_mark_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge      <= EDGE_W'(GRID_SIZE);
            r_out_valid <= 1'b0;
            r_out_hit   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_edge <= i_cfg_data;
            end
            if (scan_done && out_free) begin
                r_out_valid <= 1'b1;
                r_out_hit   <= scan_hit;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = !scan_ready;
    assign o_valid = r_out_valid;
    assign o_hit   = r_out_hit;

endmodule

@@ dv/psgmq_checker.sv @@
// Checker for the periodic grid sphere mark and query block: watches the edge register
// port and both word channels, predicts every result and compares it with the block.
// Depends on psgmq_pkg for the word layout, the grid size and the operation codes.
module psgmq_checker
    import psgmq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [EDGE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_item             i_word,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_hit,
    output int                o_errors,
    output int                o_pending
);

    bit              cell_marks [CELL_COUNT];
    logic [EDGE_W-1:0] grid_edge_q;
    logic            hit_fifo [$];
    logic            hit_exp;
    int              error_total = 0;

    function automatic logic sphere_scan(input t_item w);
        int   e;
        int   half;
        int   lim;
        int   x;
        int   y;
        int   z;
        int   d2;
        int   addr;
        logic found;
        e = int'(grid_edge_q);
        if (e == 0) e = 1;
        if (e > GRID_SIZE) e = GRID_SIZE;
        half  = int'(w.half_extent);
        lim   = int'(w.radius_sq_limit);
        found = 1'b0;
        for (int l = -half; l <= half; l++) begin
            x = ((int'(w.center_x) % e) + l) % e;
            if (x < 0) x += e;
            for (int m = -half; m <= half; m++) begin
                y = ((int'(w.center_y) % e) + m) % e;
                if (y < 0) y += e;
                for (int n = -half; n <= half; n++) begin
                    z = ((int'(w.center_z) % e) + n) % e;
                    if (z < 0) z += e;
                    d2   = l * l + m * m + n * n;
                    addr = e * (x * e + y) + z;
                    if (d2 < lim) begin
                        if (w.op == OP_MARK) begin
                            cell_marks[addr] = 1'b1;
                        end else if (cell_marks[addr]) begin
                            found = 1'b1;
                        end
                    end
                end
            end
        end
        return (w.op == OP_QUERY) && found;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grid_edge_q = EDGE_W'(GRID_SIZE);
            hit_fifo.delete();
            for (int a = 0; a < CELL_COUNT; a++) cell_marks[a] = 1'b0;
        end else begin
            // A result word always belongs to an earlier input word, so retire first.
            if (i_out_valid && !i_out_stall) begin
                if (hit_fifo.size() == 0) begin
                    $error("hit: expected none, actual %0d", i_hit);
                    error_total++;
                end else begin
                    hit_exp = hit_fifo.pop_front();
                    if (i_hit !== hit_exp) begin
                        $error("hit: expected %0d, actual %0d", hit_exp, i_hit);
                        error_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) hit_fifo.push_back(sphere_scan(i_word));
            if (i_cfg_we) grid_edge_q = i_cfg_data;
        end
        o_errors  <= error_total;
        o_pending <= hit_fifo.size();
    end

endmodule

@@ dv/tb_periodic_grid_sphere_mark_query.sv @@
// Testbench top for the periodic grid sphere mark and query block: drives reset, the edge
// register and the input words, stalls the result channel and gives the verdict.
// Depends on psgmq_pkg, periodic_grid_sphere_mark_query and psgmq_checker.
module tb_periodic_grid_sphere_mark_query;
    import psgmq_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [EDGE_W-1:0]  i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic               i_op;
    logic [COORD_W-1:0] i_center_x;
    logic [COORD_W-1:0] i_center_y;
    logic [COORD_W-1:0] i_center_z;
    logic [HALF_W-1:0]  i_half_extent;
    logic [LIMIT_W-1:0] i_radius_sq_limit;
    logic               o_valid;
    logic               i_stall;
    logic               o_hit;

    int error_count;
    int pending_words;
    int send_idle_pct = 24;
    int take_idle_pct = 55;
    int edge_plan [6] = '{5, 64, 2, 127, 9, 64};

    periodic_grid_sphere_mark_query u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_center_x        (i_center_x),
        .i_center_y        (i_center_y),
        .i_center_z        (i_center_z),
        .i_half_extent     (i_half_extent),
        .i_radius_sq_limit (i_radius_sq_limit),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_hit             (o_hit)
    );

    psgmq_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_word      ({i_op, i_center_x, i_center_y, i_center_z, i_half_extent,
                       i_radius_sq_limit}),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_hit       (o_hit),
        .o_errors    (error_count),
        .o_pending   (pending_words)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < take_idle_pct);
    end

    task automatic drive_word(input logic op, input int cx, input int cy, input int cz,
                              input int h, input int lim);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_op              <= op;
        i_center_x        <= COORD_W'(cx);
        i_center_y        <= COORD_W'(cy);
        i_center_z        <= COORD_W'(cz);
        i_half_extent     <= HALF_W'(h);
        i_radius_sq_limit <= LIMIT_W'(lim);
        do @(posedge i_clk); while (o_stall);
    endtask

    // The edge is only changed once every word in flight has returned its result.
    task automatic write_edge(input int value);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= EDGE_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int   mark_x [8];
        int   mark_y [8];
        int   mark_z [8];
        int   n_marks;
        int   pick;
        logic op;
        int   cx;
        int   cy;
        int   cz;
        int   h;
        int   lim;
        n_marks           = 0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= '0;
        i_valid           <= 1'b0;
        i_stall           <= 1'b0;
        i_op              <= OP_MARK;
        i_center_x        <= '0;
        i_center_y        <= '0;
        i_center_z        <= '0;
        i_half_extent     <= '0;
        i_radius_sq_limit <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_edge(127);
        drive_word(OP_QUERY, 0, 0, 0, 0, 1);
        drive_word(OP_MARK, 0, 0, 0, 2, 0);
        drive_word(OP_QUERY, 0, 0, 0, 2, 4095);
        drive_word(OP_MARK, 63, 63, 63, 1, 2);
        drive_word(OP_QUERY, 0, 0, 0, 1, 4);
        drive_word(OP_QUERY, 0, 0, 0, 1, 3);
        drive_word(OP_QUERY, 63, 63, 63, 1, 0);
        drive_word(OP_MARK, 20, 40, 10, 3, 4095);
        drive_word(OP_QUERY, 24, 40, 10, 0, 1);
        drive_word(OP_QUERY, 23, 43, 13, 0, 1);
        drive_word(OP_QUERY, 10, 10, 10, 31, 4095);
        write_edge(0);
        drive_word(OP_MARK, 40, 5, 63, 3, 1);
        drive_word(OP_QUERY, 1, 2, 3, 4, 2);
        write_edge(3);
        drive_word(OP_QUERY, 7, 7, 7, 2, 5);
        drive_word(OP_MARK, 62, 1, 33, 5, 12);
        drive_word(OP_QUERY, 0, 0, 0, 0, 1);
        write_edge(64);
        drive_word(OP_QUERY, 0, 0, 0, 1, 2);
        drive_word(OP_QUERY, 0, 0, 1, 0, 1);
        drive_word(OP_MARK, 31, 31, 31, 4, 17);
        drive_word(OP_QUERY, 35, 31, 31, 0, 1);
        drive_word(OP_QUERY, 36, 31, 31, 1, 2);

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 24 : (p == 1) ? 55 : 0;
            take_idle_pct = (p == 0) ? 55 : (p == 1) ? 24 : 0;
            for (int s = 0; s < 2; s++) begin
                write_edge(edge_plan[2 * p + s]);
                for (int k = 0; k < 17; k++) begin
                    op = 1'($urandom_range(1));
                    h  = ($urandom_range(9) == 0) ? $urandom_range(6, 4) : $urandom_range(3);
                    if (op == OP_QUERY && n_marks > 0 && $urandom_range(99) < 65) begin
                        pick = $urandom_range(((n_marks < 8) ? n_marks : 8) - 1);
                        cx   = (mark_x[pick] + $urandom_range(2) - 1) & 63;
                        cy   = (mark_y[pick] + $urandom_range(2) - 1) & 63;
                        cz   = (mark_z[pick] + $urandom_range(2) - 1) & 63;
                    end else begin
                        cx = $urandom_range(63);
                        cy = $urandom_range(63);
                        cz = $urandom_range(63);
                    end
                    if ($urandom_range(7) == 0) begin
                        lim = $urandom_range(4095);
                    end else begin
                        lim = $urandom_range(3 * h * h + 1);
                    end
                    if (op == OP_MARK) begin
                        mark_x[n_marks % 8] = cx;
                        mark_y[n_marks % 8] = cy;
                        mark_z[n_marks % 8] = cz;
                        n_marks++;
                    end
                    drive_word(op, cx, cy, cz, h, lim);
                end
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_words == 0) begin
            $display("tb_periodic_grid_sphere_mark_query: clean");
        end else begin
            $display("tb_periodic_grid_sphere_mark_query: errors");
        end
        $finish;
    end

    initial begin
        #48_000_000;
        $display("tb_periodic_grid_sphere_mark_query: errors");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/psgmq_pkg.sv
hw/rtl/psgmq_mark_ram.sv
hw/rtl/psgmq_scan.sv
hw/rtl/periodic_grid_sphere_mark_query.sv
dv/psgmq_checker.sv
dv/tb_periodic_grid_sphere_mark_query.sv
